// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL, included by the top-level queue file.
// Depends on a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== hdl/dcq_pkg.sv =====
// Shared types, constants and helpers for the deadline callout queue.
// No dependencies.
`default_nettype none
package dcq_pkg;
  localparam int ENTRIES_DEF  = 16;
  localparam int MAX_FIRE_DEF = 16;
  localparam int ID_W  = 4;
  localparam int DL_W  = 63;
  localparam int PER_W = 32;
  localparam int CLK_W = 64;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ABS   = 2'd1,
    OP_DELAY = 2'd2,
    OP_CANCEL = 2'd3
  } op_t;

  typedef struct packed {
    logic load_in;
    logic clk_inc;
    logic cnt_clr;
    logic remove_id;
    logic fire;
    logic new_sched;
    logic new_period;
    logic scan_clr;
    logic scan_step;
    logic insert;
    logic out_load;
    logic out_last;
  } dcq_cmd_t;

  typedef struct packed {
    op_t  op;
    logic id_ok;
    logic scan_done;
    logic head_due;
    logic per_nz;
    logic out_free;
  } dcq_stat_t;

  // saturating 63-bit add
  function automatic logic [DL_W-1:0] sat_add63(input logic [DL_W-1:0] a,
                                                input logic [DL_W-1:0] b);
    logic [DL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DL_W] ? {DL_W{1'b1}} : s[DL_W-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/dcq_datapath.sv =====
// Datapath: clock, sorted slot array, scan pointer, fire holding and output register.
// Depends on dcq_pkg.
`default_nettype none
module dcq_datapath import dcq_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int MAX_FIRE = MAX_FIRE_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [103:0] s_axis_tdata,
  input  wire dcq_cmd_t     cmd,
  output dcq_stat_t         stat,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata,
  output logic              m_axis_tlast
);
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int CW = $clog2(MAX_FIRE + 1);

  logic [CLK_W-1:0] clock_now;
  op_t              op_r;
  logic [ID_W-1:0]  id_r;
  logic [DL_W-1:0]  tv_r;
  logic [PER_W-1:0] per_r;

  logic [ID_W-1:0]  slot_id  [ENTRIES];
  logic [DL_W-1:0]  slot_dl  [ENTRIES];
  logic [PER_W-1:0] slot_per [ENTRIES];
  logic [LW-1:0]    q_len;
  logic [IW-1:0]    ptr;
  logic [CW-1:0]    fire_cnt;

  logic [ID_W-1:0]  new_id, hold_id, out_entry;
  logic [DL_W-1:0]  new_dl, hold_dl, out_deadline;
  logic [PER_W-1:0] new_per, hold_per;

  logic [ENTRIES-1:0] sel, shift_dn;
  logic [DL_W-1:0]    base;

  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      if (cmd.fire) begin
        sel[k] = (k == 0);
      end else begin
        sel[k] = (LW'(k) < q_len) && (slot_id[k] == id_r);
      end
    end
    shift_dn[0] = sel[0];
    for (int k = 1; k < ENTRIES; k++) begin
      shift_dn[k] = shift_dn[k-1] | sel[k];
    end
  end

  assign base = clock_now[CLK_W-1] ? {DL_W{1'b1}} : clock_now[DL_W-1:0];

  assign stat.op        = op_r;
  assign stat.id_ok     = (32'(id_r) < ENTRIES);
  assign stat.scan_done = (LW'(ptr) == q_len) || (slot_dl[ptr] > new_dl);
  assign stat.head_due  = (q_len != '0) && ({1'b0, slot_dl[0]} <= clock_now)
                          && (fire_cnt < CW'(MAX_FIRE));
  assign stat.per_nz    = (slot_per[0] != '0);
  assign stat.out_free  = !m_axis_tvalid || m_axis_tready;

  assign m_axis_tdata = {5'd0, out_deadline, out_entry};

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= op_t'(s_axis_tdata[1:0]);
      id_r  <= s_axis_tdata[5:2];
      tv_r  <= s_axis_tdata[68:6];
      per_r <= s_axis_tdata[100:69];
    end
    if (cmd.fire) begin
      hold_id  <= slot_id[0];
      hold_dl  <= slot_dl[0];
      hold_per <= slot_per[0];
    end
    if (cmd.new_sched) begin
      new_id <= id_r;
      if (op_r == OP_DELAY) begin
        new_dl  <= sat_add63(base, tv_r);
        new_per <= per_r;
      end else begin
        new_dl  <= tv_r;
        new_per <= '0;
      end
    end
    if (cmd.new_period) begin
      new_id  <= hold_id;
      new_dl  <= sat_add63(hold_dl, {{(DL_W-PER_W){1'b0}}, hold_per});
      new_per <= hold_per;
    end
    if (cmd.remove_id || cmd.fire) begin
      for (int k = 0; k < ENTRIES - 1; k++) begin
        if (shift_dn[k]) begin
          slot_id[k]  <= slot_id[k+1];
          slot_dl[k]  <= slot_dl[k+1];
          slot_per[k] <= slot_per[k+1];
        end
      end
    end else if (cmd.insert) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (k > int'(ptr)) begin
          slot_id[k]  <= slot_id[k-1];
          slot_dl[k]  <= slot_dl[k-1];
          slot_per[k] <= slot_per[k-1];
        end else if (k == int'(ptr)) begin
          slot_id[k]  <= new_id;
          slot_dl[k]  <= new_dl;
          slot_per[k] <= new_per;
        end
      end
    end
    if (cmd.out_load) begin
      out_entry    <= hold_id;
      out_deadline <= hold_dl;
      m_axis_tlast <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_now     <= '0;
      q_len         <= '0;
      ptr           <= '0;
      fire_cnt      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cmd.clk_inc) clock_now <= clock_now + 64'd1;
      if (cmd.remove_id || cmd.fire) begin
        q_len <= q_len - LW'(shift_dn[ENTRIES-1]);
      end else if (cmd.insert) begin
        q_len <= q_len + LW'(1);
      end
      if (cmd.scan_clr) begin
        ptr <= '0;
      end else if (cmd.scan_step) begin
        ptr <= ptr + IW'(1);
      end
      if (cmd.cnt_clr) begin
        fire_cnt <= '0;
      end else if (cmd.fire) begin
        fire_cnt <= fire_cnt + CW'(1);
      end
      if (cmd.out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/dcq_ctrl.sv =====
// Controller state machine sequencing schedule, cancel and tick operations.
// Depends on dcq_pkg.
`default_nettype none
module dcq_ctrl import dcq_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_axis_tvalid,
  output logic           s_axis_tready,
  input  wire dcq_stat_t stat,
  output dcq_cmd_t       cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_REMOVE, S_SETNEW, S_SCAN, S_INSERT,
    S_CHECK, S_FIRE, S_PERADD
  } state_t;

  state_t state, state_next;
  logic   pend, pend_next;

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    pend_next  = pend;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op == OP_TICK) begin
          cmd.clk_inc = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_next  = S_CHECK;
        end else if (stat.id_ok) begin
          state_next = S_REMOVE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_REMOVE: begin
        cmd.remove_id = 1'b1;
        state_next    = (stat.op == OP_CANCEL) ? S_IDLE : S_SETNEW;
      end
      S_SETNEW: begin
        cmd.new_sched = 1'b1;
        cmd.scan_clr  = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_INSERT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = (stat.op == OP_TICK) ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (pend) begin
          if (stat.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_last = !stat.head_due;
            pend_next    = 1'b0;
            state_next   = stat.head_due ? S_FIRE : S_IDLE;
          end
        end else begin
          state_next = stat.head_due ? S_FIRE : S_IDLE;
        end
      end
      S_FIRE: begin
        cmd.fire   = 1'b1;
        pend_next  = 1'b1;
        state_next = stat.per_nz ? S_PERADD : S_CHECK;
      end
      S_PERADD: begin
        cmd.new_period = 1'b1;
        cmd.scan_clr   = 1'b1;
        state_next     = S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/deadline_callout_queue.sv =====
// Deadline callout queue: 64-bit tick clock plus a deadline-sorted timer queue.
// One word in flight at a time. Schedule: accept, decode, remove the old entry,
// set the deadline, scan, insert. Cancel stops after removal, an ignored id after
// decode. Tick: clock +1, fire due entries, re-insert periodic ones, wait on output.
// Synchronous active-high reset empties the queue and zeroes the clock at once.
`default_nettype none
module deadline_callout_queue import dcq_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int MAX_FIRE = MAX_FIRE_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // operation[1:0], entry_id[5:2], time_value[68:6], period[100:69], zero pad
  input  wire logic [103:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // fired_entry[3:0], fired_deadline[66:4], zero pad
  output logic [71:0]       m_axis_tdata,
  // last firing of this tick
  output logic              m_axis_tlast
);
  dcq_cmd_t  cmd;
  dcq_stat_t stat;

  dcq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // slots stay sorted by deadline; ties keep arrival order since insert goes
  // after every slot whose deadline is not later
  dcq_datapath #(
    .ENTRIES  (ENTRIES),
    .MAX_FIRE (MAX_FIRE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .cmd           (cmd),
    .stat          (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`include "assert_macros.svh"
  `ASSERT_CLK(a_one_word, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "second word taken while busy")
  `ASSERT_CLK(a_out_room, cmd.out_load |-> stat.out_free, "result overwrote a waiting word")
  `ASSERT_CLK(a_fire_due, cmd.fire |-> stat.head_due, "fired an entry that was not due")
endmodule
`default_nettype wire

// ===== bench/deadline_callout_queue_tb.sv =====
// Self-checking bench for deadline_callout_queue: directed table, a full-queue output stall, then random traffic.
// Depends on dcq_pkg and the deadline_callout_queue RTL; no files, no arguments.
`default_nettype none
module deadline_callout_queue_tb;
  import dcq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NQ = 16;
  localparam logic [62:0] DL_MAX = {63{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic m_axis_tlast;

  always #6 clk = ~clk;

  deadline_callout_queue dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  typedef struct packed {
    logic [3:0]  entry;
    logic [62:0] deadline;
    logic        last;
  } firing_t;

  typedef struct {
    op_t         op;
    logic [3:0]  id;
    logic [62:0] tv;
    logic [31:0] per;
    int          nfire;   // -1: predictor only; else typed-in firing count
    logic [3:0]  f_id;    // typed-in first firing when nfire > 0
    logic [62:0] f_dl;
  } stim_t;

  // predictor state
  logic [63:0] sim_now;
  logic [62:0] sim_dl[NQ];
  logic [31:0] sim_per[NQ];
  logic [3:0]  sim_q[NQ];
  int          sim_len;

  firing_t pending_firings[$];
  int errors = 0;
  int words_sent = 0;
  int firings_seen = 0;
  bit hold_off = 1'b0;

  function automatic logic [62:0] sat63(logic [62:0] a, logic [62:0] b);
    logic [63:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[63] ? DL_MAX : s[62:0];
  endfunction

  function automatic void q_remove(logic [3:0] id);
    int p;
    p = -1;
    for (int i = 0; i < sim_len; i++) if (p < 0 && sim_q[i] == id) p = i;
    if (p < 0) return;
    for (int i = p; i + 1 < sim_len; i++) sim_q[i] = sim_q[i+1];
    sim_len--;
  endfunction

  // stable insert: after every entry whose deadline is not later
  function automatic void q_insert(logic [3:0] id);
    int pos;
    if (sim_len >= NQ) return;
    pos = 0;
    while (pos < sim_len && sim_dl[sim_q[pos]] <= sim_dl[id]) pos++;
    for (int i = sim_len; i > pos; i--) sim_q[i] = sim_q[i-1];
    sim_q[pos] = id;
    sim_len++;
  endfunction

  // apply one word to the timer model; returns number of firings queued
  function automatic int timer_apply(op_t op, logic [3:0] id, logic [62:0] tv,
                                     logic [31:0] per);
    int n;
    logic [3:0] head;
    logic [62:0] d, base;
    firing_t f;
    n = 0;
    case (op)
      OP_TICK: begin
        sim_now = sim_now + 64'd1;
        while (n < 16 && sim_len > 0) begin
          head = sim_q[0];
          d = sim_dl[head];
          if ({1'b0, d} > sim_now) break;
          q_remove(head);
          sim_dl[head] = '0;
          f.entry = head; f.deadline = d; f.last = 1'b0;
          pending_firings.push_back(f);
          n++;
          if (sim_per[head] != 0) begin
            sim_dl[head] = sat63(d, {31'd0, sim_per[head]});
            q_insert(head);
          end
        end
        if (n > 0) pending_firings[$].last = 1'b1;
      end
      OP_ABS: begin
        q_remove(id); sim_dl[id] = tv; sim_per[id] = '0; q_insert(id);
      end
      OP_DELAY: begin
        base = sim_now[63] ? DL_MAX : sim_now[62:0];
        q_remove(id); sim_dl[id] = sat63(base, tv); sim_per[id] = per; q_insert(id);
      end
      default: begin
        q_remove(id); sim_dl[id] = '0; sim_per[id] = '0;
      end
    endcase
    return n;
  endfunction

  // sender: random gap, then offer one word until accepted; valid stays up
  // across a zero gap so back-to-back words need no second update of it
  task automatic send_word(op_t op, logic [3:0] id, logic [62:0] tv, logic [31:0] per);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'd0, per, tv, id, op};
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  // random word, biased toward well-formed traffic with near deadlines
  task automatic send_random();
    op_t op;
    logic [3:0] id;
    logic [62:0] tv;
    logic [31:0] per;
    int r;
    r = $urandom_range(0, 99);
    op = (r < 45) ? OP_TICK : (r < 65) ? OP_ABS : (r < 88) ? OP_DELAY : OP_CANCEL;
    id = 4'($urandom_range(0, 15));
    per = ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
    if ($urandom_range(0, 19) == 0)
      per = 32'({$urandom, $urandom} >> $urandom_range(0, 31));
    if ($urandom_range(0, 9) == 0)
      tv = 63'({$urandom, $urandom} >> $urandom_range(1, 62));
    else if (op == OP_ABS)
      tv = sim_now[62:0] + 63'($urandom_range(0, 8));
    else
      tv = 63'($urandom_range(0, 8));
    if ($urandom_range(0, 29) == 0) tv = {63{1'b1}} ^ 63'($urandom_range(0, 3));
    void'(timer_apply(op, id, tv, per));
    send_word(op, id, tv, per);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        for (int c = 0; c < 400; c++) @(posedge clk);
        hold_off = 1'b0;
      end
      stall = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 1);
      if ($urandom_range(0, 2) == 0) stall = 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // checker: compare each accepted firing with the oldest expectation
  always @(posedge clk) begin
    firing_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      firings_seen++;
      if (pending_firings.size() == 0) begin
        $error("unexpected firing entry=%0d", m_axis_tdata[3:0]);
        errors++;
      end else begin
        e = pending_firings.pop_front();
        if (m_axis_tdata[3:0] !== e.entry) begin
          $error("fired_entry exp %0d got %0d", e.entry, m_axis_tdata[3:0]); errors++;
        end
        if (m_axis_tdata[66:4] !== e.deadline) begin
          $error("fired_deadline exp %0d got %0d", e.deadline, m_axis_tdata[66:4]);
          errors++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("last exp %0b got %0b", e.last, m_axis_tlast); errors++;
        end
      end
    end
  end

  stim_t plan[$];

  function automatic stim_t row(op_t op, logic [3:0] id, logic [62:0] tv, logic [31:0] per,
                                int nf = -1, logic [3:0] fid = '0, logic [62:0] fdl = '0);
    stim_t s;
    s.op = op; s.id = id; s.tv = tv; s.per = per;
    s.nfire = nf; s.f_id = fid; s.f_dl = fdl;
    return s;
  endfunction

  initial begin
    int n, base;
    sim_now = '0; sim_len = 0;
    for (int i = 0; i < NQ; i++) begin
      sim_dl[i] = '0; sim_per[i] = '0; sim_q[i] = '0;
    end
    // directed table: reset state, deadline zero, equal deadlines, overflow cases
    plan.push_back(row(OP_TICK,   4'd0,  '0, '0, 0));             // empty queue
    plan.push_back(row(OP_ABS,    4'd15, '0, 32'hFFFF_FFFF));     // deadline zero
    plan.push_back(row(OP_TICK,   4'd0,  '0, '0, 1, 4'd15, '0));
    plan.push_back(row(OP_ABS,    4'd3,  63'd5, '0));
    plan.push_back(row(OP_ABS,    4'd7,  63'd5, '0));             // equal deadlines
    plan.push_back(row(OP_ABS,    4'd3,  63'd5, '0));             // re-schedule moves it
    plan.push_back(row(OP_CANCEL, 4'd9,  '0, '0));                // not queued
    plan.push_back(row(OP_DELAY,  4'd0,  63'd1, 32'd1));          // fast periodic
    plan.push_back(row(OP_TICK,   4'd0,  '0, '0));
    plan.push_back(row(OP_TICK,   4'd0,  '0, '0));
    plan.push_back(row(OP_TICK,   4'd0,  '0, '0));
    plan.push_back(row(OP_CANCEL, 4'd0,  '0, '0));
    plan.push_back(row(OP_DELAY,  4'd1,  DL_MAX, 32'd3));          // delay saturates
    plan.push_back(row(OP_ABS,    4'd2,  DL_MAX - 1, '0));
    plan.push_back(row(OP_DELAY,  4'd4,  63'd0, 32'hFFFF_FFFF));   // due now, big period
    plan.push_back(row(OP_TICK,   4'd0,  '0, '0));
    plan.push_back(row(OP_ABS,    4'd5,  63'd2, '0));              // overdue: several at once
    plan.push_back(row(OP_ABS,    4'd6,  63'd1, '0));
    plan.push_back(row(OP_DELAY,  4'd8,  63'd0, 32'd1));           // periodic, due now
    plan.push_back(row(OP_TICK,   4'd0,  '0, '0));
    plan.push_back(row(OP_CANCEL, 4'd8,  '0, '0));
    plan.push_back(row(OP_CANCEL, 4'd4,  '0, '0));
    plan.push_back(row(OP_TICK,   4'd0,  '0, '0));
    plan.push_back(row(OP_CANCEL, 4'd1,  '0, '0));
    plan.push_back(row(OP_CANCEL, 4'd2,  '0, '0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      base = pending_firings.size();
      n = timer_apply(plan[i].op, plan[i].id, plan[i].tv, plan[i].per);
      if (plan[i].nfire >= 0) begin
        if (n != plan[i].nfire) begin
          $error("row %0d firing count exp %0d got %0d", i, plan[i].nfire, n); errors++;
        end
        if (n > 0 && (pending_firings[base].entry != plan[i].f_id ||
                      pending_firings[base].deadline != plan[i].f_dl)) begin
          $error("row %0d first firing differs from table", i); errors++;
        end
      end
      send_word(plan[i].op, plan[i].id, plan[i].tv, plan[i].per);
    end

    // fill all entries with due periodic timers, then back up the output
    for (int i = 0; i < 16; i++) begin
      void'(timer_apply(OP_DELAY, 4'(i), 63'd0, 32'd1));
      send_word(OP_DELAY, 4'(i), 63'd0, 32'd1);
    end
    hold_off = 1'b1;
    for (int i = 0; i < 4; i++) begin
      void'(timer_apply(OP_TICK, '0, '0, '0));
      send_word(OP_TICK, '0, '0, '0);
    end
    for (int i = 0; i < 16; i++) begin
      void'(timer_apply(OP_CANCEL, 4'(i), '0, '0));
      send_word(OP_CANCEL, 4'(i), '0, '0);
    end

    for (int i = 0; i < 270; i++) send_random();
    s_axis_tvalid <= 1'b0;

    while (pending_firings.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d words and %0d firings incl. saturation, periodic and stall",
             words_sent, firings_seen);
    if (errors == 0 && pending_firings.size() == 0)
      $display("deadline_callout_queue_tb: done, clean");
    else
      $display("deadline_callout_queue_tb: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("deadline_callout_queue_tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

// ===== deadline_callout_queue.f =====
+incdir+hdl
hdl/dcq_pkg.sv
hdl/dcq_datapath.sv
hdl/dcq_ctrl.sv
hdl/deadline_callout_queue.sv
bench/deadline_callout_queue_tb.sv
